[sv/smooth_weighted_rr_with_fail_track_macros.svh]
// Assertion macros shared by the checker.
`ifndef SMOOTH_WEIGHTED_RR_WITH_FAIL_TRACK_MACROS_SVH
`define SMOOTH_WEIGHTED_RR_WITH_FAIL_TRACK_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SWRR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same, but also checked while reset is high.
`define SWRR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[sv/swrr_pkg.sv]
// Shared types and constants for the weighted backend selector.
`default_nettype none
package swrr_pkg;
  localparam int NB = 8;
  localparam logic CMD_CHOOSE = 1'b0;
  localparam logic CMD_REPORT = 1'b1;
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_WEIGHT = 2'd1;
  localparam logic [1:0] REG_FTIME = 2'd2;
  localparam logic [1:0] REG_FCOUNT = 2'd3;
  localparam logic signed [12:0] CW_MAX = 13'sd4095;
  localparam logic signed [12:0] CW_MIN = -13'sd4095 - 13'sd1;

  typedef struct packed {
    logic       cmd;
    logic [2:0] target;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [2:0] backend;
    logic       valid;
    logic       down;
  } result_t;
endpackage
`default_nettype wire

[sv/swrr_queue.sv]
// Two-entry queue between front and back.
`default_nettype none
module swrr_queue
  import swrr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);
  item_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;
  assign in_ready = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_item = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_item;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[sv/swrr_div.sv]
// Restoring 8-bit divider, one quotient bit a cycle.
`default_nettype none
module swrr_div (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [7:0] dividend,
  input  wire logic [7:0] divisor,
  output logic            done,
  output logic [7:0]      quotient
);
  logic [7:0] rem, quo, dvs;
  logic [3:0] cnt;
  logic busy;
  logic [8:0] trial;
  assign trial = {rem[7:0], quo[7]} - {1'b0, dvs};
  assign quotient = quo;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; cnt <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= 4'd0; rem <= 8'd0; quo <= dividend; dvs <= divisor;
      end else if (busy) begin
        if (!trial[8]) begin
          rem <= trial[7:0]; quo <= {quo[6:0], 1'b1};
        end else begin
          rem <= {rem[6:0], quo[7]}; quo <= {quo[6:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd7) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[sv/swrr_back.sv]
// Back end: walks the backends for a choose, updates failure state for a report.
`default_nettype none
module swrr_back
  import swrr_pkg::*;
#(
  parameter int NUM_BACKENDS = 8,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire item_t       in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output result_t          out_res
);
  localparam int IW = (NUM_BACKENDS > 1) ? $clog2(NUM_BACKENDS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_WALK = 5'b00010, S_FIN = 5'b00100,
    S_DIV = 5'b01000, S_REP = 5'b10000
  } state_t;

  logic [3:0]  backend_count;
  logic [63:0] weight_table;
  logic [30:0] fail_time;
  logic [7:0]  fail_cnt;

  logic signed [12:0] cw [NUM_BACKENDS];
  logic [7:0]  ew [NUM_BACKENDS];
  logic        dn [NUM_BACKENDS];
  logic [7:0]  ec [NUM_BACKENDS];
  logic [31:0] fet [NUM_BACKENDS];
  logic [31:0] dt [NUM_BACKENDS];
  logic [2:0]  rr_pointer;

  state_t state;
  item_t  it;
  logic [3:0] k;
  logic [2:0] idx;
  logic [2:0] best;
  logic       have_best;
  logic [11:0] total;
  logic        weighted;
  logic [3:0]  n;
  logic        res_v;
  result_t     res;
  logic        div_start, div_done;
  logic [7:0]  div_q;

  function automatic logic [7:0] cfgw(input logic [63:0] tbl, input logic [2:0] i);
    logic [7:0] b;
    b = tbl[{i, 3'b000} +: 8] & 8'((9'd1 << WEIGHT_BITS) - 9'd1);
    return (b == 8'd0) ? 8'd1 : b;
  endfunction

  // next round-robin position, (p + 1) mod cnt for cnt in 1..8
  function automatic logic [2:0] rr_wrap(input logic [2:0] p, input logic [3:0] cnt);
    logic [3:0] v;
    v = 4'(p) + 4'd1;
    case (cnt)
      4'd1: v = 4'd0;
      4'd2: v = {3'd0, v[0]};
      4'd3: begin
        if (v >= 4'd6) v = v - 4'd6;
        else if (v >= 4'd3) v = v - 4'd3;
      end
      4'd4: v = {2'd0, v[1:0]};
      default: if (v >= cnt) v = v - cnt;
    endcase
    return v[2:0];
  endfunction

  assign n = (backend_count > 4'(NUM_BACKENDS)) ? 4'(NUM_BACKENDS) : backend_count;
  logic checking;
  assign checking = (fail_time != 31'd0) && (fail_cnt != 8'd0);

  // weighted-mode decision: sum of weights over active backends
  logic [11:0] wsum;
  always_comb begin
    wsum = 12'd0;
    for (int i = 0; i < NUM_BACKENDS; i++)
      if (4'(i) < n) wsum = wsum + 12'(cfgw(weight_table, 3'(i)));
  end

  // availability of the backend under the walk, with recovery
  logic [31:0] dd, fd;
  logic        recov, avail;
  logic [2:0]  ri;
  assign ri = idx;
  assign dd = it.now - dt[ri[IW-1:0]];
  assign recov = !dd[31] && (dd[30:0] >= fail_time);
  assign avail = !checking || !dn[ri[IW-1:0]] || recov;

  logic signed [13:0] csum;
  logic signed [12:0] cnew;
  assign csum = 14'(cw[idx[IW-1:0]]) + 14'($signed({6'd0, ew[idx[IW-1:0]]}));
  assign cnew = (csum > 14'(CW_MAX)) ? CW_MAX : csum[12:0];
  logic signed [13:0] csub;
  assign csub = 14'(cw[best[IW-1:0]]) - 14'($signed({2'b00, total}));

  logic [2:0] rr_next;
  assign rr_next = rr_wrap(rr_pointer, n);

  assign fd = it.now - fet[it.target[IW-1:0]];

  swrr_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(cfgw(weight_table, it.target)), .divisor(fail_cnt),
    .done(div_done), .quotient(div_q)
  );

  assign in_ready = (state == S_IDLE) && !res_v;
  assign out_valid = res_v;
  assign out_res = res;
  assign div_start = (state == S_DIV) && (k == 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      backend_count <= 4'd1;
      weight_table <= 64'h0101010101010101;
      fail_time <= 31'd5000;
      fail_cnt <= 8'd10;
      for (int i = 0; i < NUM_BACKENDS; i++) begin
        cw[i] <= '0; ew[i] <= cfgw(64'h0101010101010101, 3'(i));
        dn[i] <= 1'b0; ec[i] <= 8'd0; fet[i] <= 32'd0; dt[i] <= 32'd0;
      end
      rr_pointer <= 3'd0;
      state <= S_IDLE; res_v <= 1'b0; k <= 4'd0;
    end else begin
      if (res_v && out_ready) res_v <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          REG_COUNT:  backend_count <= cfg_data[3:0];
          REG_WEIGHT: begin
            weight_table <= cfg_data;
            for (int i = 0; i < NUM_BACKENDS; i++) begin
              ew[i] <= cfgw(cfg_data, 3'(i)); cw[i] <= '0;
            end
          end
          REG_FTIME:  fail_time <= cfg_data[30:0];
          REG_FCOUNT: fail_cnt <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          it <= in_item; k <= 4'd0; have_best <= 1'b0; total <= 12'd0;
          weighted <= (wsum != 12'(n)) && (n != 4'd1);
          if (in_item.cmd == CMD_REPORT) begin
            if ({1'b0, in_item.target} < n && checking) state <= S_DIV;
            else begin
              res <= '{backend: in_item.target, valid: 1'b0, down: 1'b0};
              res_v <= 1'b1;
            end
          end else if (n == 4'd0) begin
            res <= '{backend: 3'd0, valid: 1'b0, down: 1'b0}; res_v <= 1'b1;
          end else begin
            state <= S_WALK;
            idx <= (wsum != 12'(n)) && (n != 4'd1) ? 3'd0 : rr_next;
          end
        end
        S_WALK: begin
          // recover the visited backend if its down time is over
          if (checking && dn[idx[IW-1:0]] && recov) begin
            dn[idx[IW-1:0]] <= 1'b0; ec[idx[IW-1:0]] <= 8'd0;
          end
          if (weighted) begin
            if (avail) begin
              cw[idx[IW-1:0]] <= cnew;
              total <= total + 12'(ew[idx[IW-1:0]]);
              if (ew[idx[IW-1:0]] < cfgw(weight_table, idx))
                ew[idx[IW-1:0]] <= ew[idx[IW-1:0]] + 8'd1;
              if (!have_best || cnew > cw[best[IW-1:0]]) begin
                best <= idx; have_best <= 1'b1;
              end
            end
            if (4'(idx) + 4'd1 >= n) state <= S_FIN;
            else idx <= idx + 3'd1;
          end else begin
            rr_pointer <= idx;
            k <= k + 4'd1;
            if (avail) begin
              res <= '{backend: idx, valid: 1'b1, down: 1'b0};
              res_v <= 1'b1; state <= S_IDLE;
            end else if (k + 4'd1 >= n) begin
              res <= '{backend: 3'd0, valid: 1'b0, down: 1'b0};
              res_v <= 1'b1; state <= S_IDLE;
            end else idx <= (4'(idx) + 4'd1 >= n) ? 3'd0 : idx + 3'd1;
          end
        end
        S_FIN: begin
          if (have_best)
            cw[best[IW-1:0]] <= (csub < 14'(CW_MIN)) ? CW_MIN : csub[12:0];
          res <= '{backend: have_best ? best : 3'd0, valid: have_best, down: 1'b0};
          res_v <= 1'b1; state <= S_IDLE;
        end
        S_DIV: begin
          k <= 4'd1;
          if (div_done) begin
            ew[it.target[IW-1:0]] <= (ew[it.target[IW-1:0]] > div_q) ?
                                     ew[it.target[IW-1:0]] - div_q : 8'd0;
            state <= S_REP;
          end
        end
        S_REP: begin
          logic [7:0] c;
          logic       d;
          c = ec[it.target[IW-1:0]];
          if (!fd[31] && (fd[30:0] > fail_time)) begin
            fet[it.target[IW-1:0]] <= it.now; c = 8'd0;
          end
          if (c != 8'd255) c = c + 8'd1;
          ec[it.target[IW-1:0]] <= c;
          d = dn[it.target[IW-1:0]];
          if (c >= fail_cnt) begin
            d = 1'b1; dn[it.target[IW-1:0]] <= 1'b1;
            dt[it.target[IW-1:0]] <= it.now;
          end
          res <= '{backend: it.target, valid: 1'b0, down: d};
          res_v <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/smooth_weighted_rr_with_fail_track.sv]
// Top level of the weighted backend selector with failure tracking.
// From input accept to result valid: a weighted choose walks every backend in use (n, at most
// NUM_BACKENDS), a round robin choose walks until one is available or all n are tried, a
// counted report runs the 8-step divider and then updates failure state, and an ignored report
// or a choose with no backend in use answers straight from idle. One item at a time in the back
// end, held by the per-backend walk and the shared serial divider; a two-entry queue keeps
// accepting until full. Reset (rst, sync): registers to defaults, weights reloaded, failure state cleared.
`default_nettype none
module smooth_weighted_rr_with_fail_track
  import swrr_pkg::*;
#(
  parameter int NUM_BACKENDS = 8,
  parameter int WEIGHT_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [2:0]  target_backend,
  input  wire logic [31:0] now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       chosen_backend,
  output logic             chosen_valid,
  output logic             backend_down
);
  item_t   in_item, q_item;
  logic    q_valid, q_ready;
  result_t res;

  // front: capture items into the queue
  assign in_item = '{cmd: command, target: target_backend, now: now_ms};

  swrr_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  // back: run one item and hold its result until taken
  swrr_back #(.NUM_BACKENDS(NUM_BACKENDS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign chosen_backend = res.backend;
  assign chosen_valid = res.valid;
  assign backend_down = res.down;
endmodule
`default_nettype wire

[sv/swrr_checker.sv]
// Port-level checker bound to the selector top level.
`default_nettype none
`include "smooth_weighted_rr_with_fail_track_macros.svh"
module swrr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] chosen_backend,
  input wire logic       chosen_valid,
  input wire logic       backend_down
);
  `SWRR_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `SWRR_ASSERT(a_excl, clk, rst, out_valid |-> !(chosen_valid && backend_down), "both flags")
  `SWRR_ASSERT(a_stable, clk, rst, out_valid && !out_ready |=> $stable(chosen_backend) && $stable(chosen_valid) && $stable(backend_down), "result changed while waiting")
  `SWRR_ASSERT_ALWAYS(a_rst, clk, $past(rst) |-> !out_valid, "valid after reset")
endmodule
bind smooth_weighted_rr_with_fail_track swrr_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .chosen_backend(chosen_backend), .chosen_valid(chosen_valid),
  .backend_down(backend_down)
);
`default_nettype wire
